// ===== rtl/vlc_pkg.sv =====
// shared constants, opcodes and queue entry type for the varint/varlong codec
`timescale 1ns / 1ps
package vlc_pkg;

  localparam int IntMaxBytes  = 5;
  localparam int LongMaxBytes = 10;
  localparam int GroupBits    = 7;
  localparam int ValueWidth   = 64;
  localparam int LenWidth     = 4;
  localparam int QueueDepth   = 2;

  localparam logic [6:0] GroupMask = 7'h7F;
  localparam logic [7:0] MoreFlag  = 8'h80;

  localparam logic KindByte  = 1'b0;
  localparam logic KindValue = 1'b1;

  typedef enum logic {
    OpEncode = 1'b0,
    OpDecode = 1'b1
  } op_e;

  typedef struct packed {
    op_e                   opcode;
    logic [ValueWidth-1:0] value;
    logic [7:0]            data_byte;
    logic [LenWidth-1:0]   len;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic pop;
  } q_ctrl_t;

endpackage

// ===== rtl/vlc_front.sv =====
// front end: accepts transactions, masks the value and sizes each encoding
`timescale 1ns / 1ps
module vlc_front (
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          opcode_i,
  input  logic [vlc_pkg::ValueWidth-1:0] value_in_i,
  input  logic [7:0]                    byte_in_i,
  input  logic                          long_mode_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output vlc_pkg::cmd_t                 cmd_o
);
  import vlc_pkg::*;

  logic [ValueWidth-1:0] val_masked;
  logic [LenWidth-1:0]   len_raw;
  logic [LenWidth-1:0]   max_len;

  assign val_masked = long_mode_i ? value_in_i : {32'h0, value_in_i[31:0]};
  assign max_len    = long_mode_i ? LenWidth'(LongMaxBytes) : LenWidth'(IntMaxBytes);

  // highest nonzero 7-bit group sets the length
  always_comb begin
    len_raw = LenWidth'(1);
    for (int k = 1; k < LongMaxBytes; k++) begin
      if ((val_masked >> (GroupBits * k)) != '0) begin
        len_raw = LenWidth'(k + 1);
      end
    end
  end

  always_comb begin
    cmd_o.opcode    = op_e'(opcode_i);
    cmd_o.value     = val_masked;
    cmd_o.data_byte = byte_in_i;
    cmd_o.len       = (len_raw > max_len) ? max_len : len_raw;
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i & ~q_full_i;

endmodule

// ===== rtl/vlc_queue.sv =====
// two-entry command queue between front end and execution back end
`timescale 1ns / 1ps
module vlc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  vlc_pkg::cmd_t data_i,
  input  logic          pop_i,
  output vlc_pkg::cmd_t data_o,
  output logic          full_o,
  output logic          empty_o
);
  import vlc_pkg::*;

  cmd_t       mem_q [QueueDepth];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'(QueueDepth));
  assign empty_o = (count_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o && !pop_i)) else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o)) else $error("queue underflow");

endmodule

// ===== rtl/vlc_back.sv =====
// back end: serializes encodings, accumulates decodes, holds the output register
`timescale 1ns / 1ps
module vlc_back (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           long_mode_i,
  input  vlc_pkg::cmd_t                  head_i,
  input  logic                           head_valid_i,
  output vlc_pkg::q_ctrl_t               ctrl_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           kind_o,
  output logic [7:0]                     byte_out_o,
  output logic                           last_o,
  output logic [vlc_pkg::ValueWidth-1:0] decoded_value_o,
  output logic [vlc_pkg::LenWidth-1:0]   length_o
);
  import vlc_pkg::*;

  logic                  out_valid_q, out_valid_d;
  logic                  kind_q, kind_d;
  logic [7:0]            byte_q, byte_d;
  logic                  last_q, last_d;
  logic [ValueWidth-1:0] value_q, value_d;
  logic [LenWidth-1:0]   len_q, len_d;

  logic [LenWidth-1:0]   enc_idx_q, enc_idx_d;
  logic [ValueWidth-1:0] enc_rem_q, enc_rem_d;
  logic [ValueWidth-1:0] acc_q, acc_d;
  logic [LenWidth-1:0]   bs_q, bs_d;

  logic                  load_ok;
  logic                  emit;
  logic                  pop;
  logic [ValueWidth-1:0] enc_cur;
  logic                  enc_fin;
  logic [ValueWidth-1:0] width_mask;
  logic [LenWidth-1:0]   max_len;
  logic [LenWidth-1:0]   dec_idx;
  logic [5:0]            dec_shift;
  logic [ValueWidth-1:0] dec_acc;
  logic [LenWidth-1:0]   dec_count;
  logic                  dec_end;
  logic                  is_enc;

  assign load_ok    = !out_valid_q || !out_stall_i;
  assign width_mask = long_mode_i ? '1 : {32'h0, 32'hFFFF_FFFF};
  assign max_len    = long_mode_i ? LenWidth'(LongMaxBytes) : LenWidth'(IntMaxBytes);
  assign is_enc     = (head_i.opcode == OpEncode);

  // encode path
  assign enc_cur = (enc_idx_q == '0) ? head_i.value : enc_rem_q;
  assign enc_fin = ((enc_idx_q + LenWidth'(1)) == head_i.len);

  // decode path
  assign dec_idx   = (bs_q > LenWidth'(LongMaxBytes - 1)) ? LenWidth'(LongMaxBytes - 1) : bs_q;
  assign dec_shift = 6'(dec_idx * GroupBits);
  assign dec_acc   = (acc_q | (ValueWidth'(head_i.data_byte & {1'b0, GroupMask}) << dec_shift))
                     & width_mask;
  assign dec_count = dec_idx + LenWidth'(1);
  assign dec_end   = ((head_i.data_byte & MoreFlag) == 8'h00) || (dec_count >= max_len);

  always_comb begin
    emit    = 1'b0;
    pop     = 1'b0;
    kind_d  = kind_q;
    byte_d  = byte_q;
    last_d  = last_q;
    value_d = value_q;
    len_d   = len_q;
    if (head_valid_i) begin
      if (is_enc) begin
        if (load_ok) begin
          emit    = 1'b1;
          pop     = enc_fin;
          kind_d  = KindByte;
          byte_d  = {1'b0, enc_cur[6:0]} | (enc_fin ? 8'h00 : MoreFlag);
          last_d  = enc_fin;
          value_d = '0;
          len_d   = head_i.len;
        end
      end else if (dec_end) begin
        if (load_ok) begin
          emit    = 1'b1;
          pop     = 1'b1;
          kind_d  = KindValue;
          byte_d  = 8'h00;
          last_d  = 1'b1;
          value_d = dec_acc;
          len_d   = dec_count;
        end
      end else begin
        pop = 1'b1;
      end
    end
  end

  always_comb begin
    out_valid_d = emit | (out_valid_q & out_stall_i);
    enc_idx_d   = enc_idx_q;
    enc_rem_d   = enc_rem_q;
    acc_d       = acc_q;
    bs_d        = bs_q;
    if (head_valid_i && is_enc && load_ok) begin
      enc_idx_d = enc_fin ? '0 : enc_idx_q + LenWidth'(1);
      enc_rem_d = enc_cur >> GroupBits;
    end
    if (pop && !is_enc) begin
      acc_d = dec_end ? '0 : dec_acc;
      bs_d  = dec_end ? '0 : dec_count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      enc_idx_q   <= '0;
      acc_q       <= '0;
      bs_q        <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      enc_idx_q   <= enc_idx_d;
      acc_q       <= acc_d;
      bs_q        <= bs_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q    <= kind_d;
    byte_q    <= byte_d;
    last_q    <= last_d;
    value_q   <= value_d;
    len_q     <= len_d;
    enc_rem_q <= enc_rem_d;
  end

  assign ctrl_o.valid    = head_valid_i;
  assign ctrl_o.pop      = pop;
  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign byte_out_o      = byte_q;
  assign last_o          = last_q;
  assign decoded_value_o = value_q;
  assign length_o        = len_q;

  a_bytes_seen_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bs_q <= LenWidth'(LongMaxBytes - 1)) else $error("decode count out of range");

  a_enc_idx_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    enc_idx_q != '0 |-> head_valid_i && is_enc && (enc_idx_q < head_i.len))
    else $error("encode index outside its run");

endmodule

// ===== rtl/varint_varlong_codec_top.sv =====
// top level of the varint/varlong codec: mode register, front end, queue, back end
// an accepted transaction is written into the queue, then taken into the output register
// throughput: one decode byte per cycle while the output is not stalled; an encode
// holds the back end for its 1 to 5 bytes (32-bit) or 1 to 10 bytes (64-bit)
// reset: asynchronous active low; selects 32-bit mode, clears the queue, the
// output register and the partial decode
`timescale 1ns / 1ps
module varint_varlong_codec_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic                           cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           opcode_i,
  input  logic [vlc_pkg::ValueWidth-1:0] value_in_i,
  input  logic [7:0]                     byte_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic                           kind_o,
  output logic [7:0]                     byte_out_o,
  output logic                           last_o,
  output logic [vlc_pkg::ValueWidth-1:0] decoded_value_o,
  output logic [vlc_pkg::LenWidth-1:0]   length_o
);
  import vlc_pkg::*;

  logic    long_mode_q;
  cmd_t    front_cmd;
  cmd_t    head_cmd;
  logic    push;
  logic    q_full;
  logic    q_empty;
  q_ctrl_t back_ctrl;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      long_mode_q <= cfg_wdata_i;
    end
  end

  vlc_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .value_in_i  (value_in_i),
    .byte_in_i   (byte_in_i),
    .long_mode_i (long_mode_q),
    .q_full_i    (q_full),
    .push_o      (push),
    .cmd_o       (front_cmd)
  );

  vlc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .pop_i   (back_ctrl.pop & back_ctrl.valid),
    .data_o  (head_cmd),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  vlc_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .long_mode_i     (long_mode_q),
    .head_i          (head_cmd),
    .head_valid_i    (~q_empty),
    .ctrl_o          (back_ctrl),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .byte_out_o      (byte_out_o),
    .last_o          (last_o),
    .decoded_value_o (decoded_value_o),
    .length_o        (length_o)
  );

endmodule

// ===== dv/tb.sv =====
// self-checking testbench for the varint/varlong codec: directed table, then random phases
`timescale 1ns / 1ps
module tb;
  import vlc_pkg::*;

  localparam int CycleLimit  = 300000;
  localparam int DrainCycles = 8;
  localparam int TailCycles  = 20;
  localparam int NumPhases   = 8;
  localparam int PhaseItems  = 60;

  typedef struct packed {
    logic                  kind;
    logic [7:0]            byte_out;
    logic                  last;
    logic [ValueWidth-1:0] value;
    logic [LenWidth-1:0]   length;
  } codec_result_t;

  typedef struct packed {
    logic                  mode;
    op_e                   op;
    logic [ValueWidth-1:0] value;
    logic [7:0]            data;
    logic                  typed;
    codec_result_t         res;
  } stim_row_t;

  localparam codec_result_t NoRes = '0;

  localparam stim_row_t DirectedRows [25] = '{
    '{1'b0, OpEncode, 64'h0, 8'h00, 1'b1, '{KindByte, 8'h00, 1'b1, 64'h0, 4'd1}},
    '{1'b0, OpEncode, 64'h7F, 8'h00, 1'b1, '{KindByte, 8'h7F, 1'b1, 64'h0, 4'd1}},
    '{1'b0, OpEncode, 64'h80, 8'h00, 1'b0, NoRes},
    '{1'b0, OpEncode, 64'hFFFF_FFFF, 8'h00, 1'b0, NoRes},
    '{1'b0, OpEncode, 64'hFFFF_FFFF_8000_0000, 8'h00, 1'b0, NoRes},
    '{1'b0, OpDecode, 64'h0, 8'h05, 1'b1, '{KindValue, 8'h00, 1'b1, 64'h5, 4'd1}},
    '{1'b0, OpDecode, 64'h0, 8'h80, 1'b0, NoRes},
    '{1'b0, OpDecode, 64'h0, 8'h00, 1'b1, '{KindValue, 8'h00, 1'b1, 64'h0, 4'd2}},
    '{1'b0, OpDecode, 64'h0, 8'hFF, 1'b0, NoRes},
    '{1'b0, OpDecode, 64'h0, 8'hFF, 1'b0, NoRes},
    '{1'b0, OpDecode, 64'h0, 8'hFF, 1'b0, NoRes},
    '{1'b0, OpDecode, 64'h0, 8'hFF, 1'b0, NoRes},
    '{1'b0, OpDecode, 64'h0, 8'hFF, 1'b1,
      '{KindValue, 8'h00, 1'b1, 64'hFFFF_FFFF, 4'd5}},
    '{1'b0, OpDecode, 64'h0, 8'h81, 1'b0, NoRes},
    '{1'b0, OpEncode, 64'h1, 8'h00, 1'b1, '{KindByte, 8'h01, 1'b1, 64'h0, 4'd1}},
    '{1'b0, OpDecode, 64'h0, 8'h01, 1'b0, NoRes},
    '{1'b1, OpEncode, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, NoRes},
    '{1'b1, OpEncode, 64'h8000_0000_0000_0000, 8'h00, 1'b0, NoRes},
    '{1'b1, OpDecode, 64'h0, 8'hFF, 1'b0, NoRes},
    '{1'b1, OpDecode, 64'h0, 8'hFF, 1'b0, NoRes},
    '{1'b1, OpDecode, 64'h0, 8'hFF, 1'b0, NoRes},
    '{1'b1, OpDecode, 64'h0, 8'hFF, 1'b0, NoRes},
    '{1'b1, OpDecode, 64'h0, 8'hFF, 1'b0, NoRes},
    '{1'b0, OpDecode, 64'h0, 8'hFF, 1'b0, NoRes},
    '{1'b1, OpEncode, 64'h0, 8'h00, 1'b1, '{KindByte, 8'h00, 1'b1, 64'h0, 4'd1}}
  };

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic                  cfg_wdata_i = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  opcode_i    = 1'b0;
  logic [ValueWidth-1:0] value_in_i  = '0;
  logic [7:0]            byte_in_i   = '0;
  logic                  out_stall_i = 1'b0;
  logic                  in_stall_o;
  logic                  out_valid_o;
  logic                  kind_o;
  logic [7:0]            byte_out_o;
  logic                  last_o;
  logic [ValueWidth-1:0] decoded_value_o;
  logic [LenWidth-1:0]   length_o;

  logic                  model_long = 1'b0;
  logic [ValueWidth-1:0] dec_acc    = '0;
  logic [LenWidth-1:0]   dec_count  = '0;
  codec_result_t         expected_q [$];
  codec_result_t         want_res;
  int                    mismatches  = 0;
  int                    cycle_count = 0;
  int                    items_sent  = 0;
  int                    idle_pct    = 30;
  int                    stall_pct   = 25;

  varint_varlong_codec_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .value_in_i     (value_in_i),
    .byte_in_i      (byte_in_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .byte_out_o     (byte_out_o),
    .last_o         (last_o),
    .decoded_value_o(decoded_value_o),
    .length_o       (length_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= 50) begin
      $display("mismatch %s at cycle %0d: got %h expected %h", field, cycle_count, got, want);
    end
  endtask

  // expected results of one accepted transaction; a typed row replaces the computed result
  task automatic predict_and_queue(op_e op, logic [63:0] val, logic [7:0] data,
                                   logic typed, codec_result_t typed_res);
    logic [63:0]   v;
    logic [63:0]   mask;
    logic [6:0]    groups [LongMaxBytes];
    int            len;
    int            maxb;
    int            idx;
    codec_result_t r;
    mask = model_long ? '1 : 64'h0000_0000_FFFF_FFFF;
    maxb = model_long ? LongMaxBytes : IntMaxBytes;
    if (op == OpEncode) begin
      v   = val & mask;
      len = 0;
      do begin
        groups[len] = v[6:0] & GroupMask;
        v = v >> GroupBits;
        len++;
      end while (v != 0 && len < maxb);
      for (int k = 0; k < len; k++) begin
        r.kind     = KindByte;
        r.byte_out = {1'b0, groups[k]} | ((k != len - 1) ? MoreFlag : 8'h00);
        r.last     = (k == len - 1);
        r.value    = '0;
        r.length   = LenWidth'(len);
        if (!typed) expected_q.push_back(r);
      end
    end else begin
      idx = (dec_count > 9) ? 9 : int'(dec_count);
      dec_acc = (dec_acc | ({57'd0, data[6:0]} << (idx * GroupBits))) & mask;
      if ((data & MoreFlag) == 8'h00 || idx + 1 >= maxb) begin
        r.kind     = KindValue;
        r.byte_out = 8'h00;
        r.last     = 1'b1;
        r.value    = dec_acc & mask;
        r.length   = LenWidth'(idx + 1);
        if (!typed) expected_q.push_back(r);
        dec_acc   = '0;
        dec_count = '0;
      end else begin
        dec_count = LenWidth'(idx + 1);
      end
    end
    if (typed) expected_q.push_back(typed_res);
  endtask

  task automatic send_item(op_e op, logic [63:0] val, logic [7:0] data,
                           logic typed = 1'b0, codec_result_t typed_res = '0);
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    value_in_i <= val;
    byte_in_i  <= data;
    do @(posedge clk_i); while (in_stall_o);
    predict_and_queue(op, val, data, typed, typed_res);
    items_sent++;
  endtask

  task automatic idle_gap();
    if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      opcode_i   <= 1'($urandom);
      value_in_i <= {$urandom, $urandom};
      byte_in_i  <= 8'($urandom);
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  // mode writes only once every expected transaction has come out
  task automatic set_mode(logic m);
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= m;
    @(posedge clk_i);
    model_long = m;
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= 1'($urandom);
  endtask

  function automatic logic [63:0] rand_value();
    logic [63:0] r;
    logic [63:0] mask;
    int          nbits;
    r     = {$urandom, $urandom};
    nbits = $urandom_range(0, 64);
    mask  = (nbits == 64) ? '1 : ((64'd1 << nbits) - 64'd1);
    case ($urandom_range(0, 9))
      0: return '1;
      1: return r | 64'h8000_0000_0000_0000;
      2: return r | 64'h0000_0000_8000_0000;
      default: return r & mask;
    endcase
  endfunction

  initial begin
    forever begin
      @(posedge clk_i);
      if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected transaction", decoded_value_o, '0);
      end else begin
        want_res = expected_q.pop_front();
        if (kind_o !== want_res.kind) report_mismatch("kind", kind_o, want_res.kind);
        if (byte_out_o !== want_res.byte_out) begin
          report_mismatch("byte_out", byte_out_o, want_res.byte_out);
        end
        if (last_o !== want_res.last) report_mismatch("last", last_o, want_res.last);
        if (decoded_value_o !== want_res.value) begin
          report_mismatch("decoded_value", decoded_value_o, want_res.value);
        end
        if (length_o !== want_res.length) report_mismatch("length", length_o, want_res.length);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int  target;
    int  sel;
    int  maxb;
    int  n;
    logic cont;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedRows[i]) begin
      if (DirectedRows[i].mode != model_long) set_mode(DirectedRows[i].mode);
      idle_gap();
      send_item(DirectedRows[i].op, DirectedRows[i].value, DirectedRows[i].data,
                DirectedRows[i].typed, DirectedRows[i].res);
    end

    for (int phase = 0; phase < NumPhases; phase++) begin
      if (phase == 0) set_mode(1'b0);
      else if (phase == 1) set_mode(1'b1);
      else set_mode(1'($urandom));
      if (phase == NumPhases - 1) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 20;
          default: idle_pct = 50;
        endcase
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 25;
          default: stall_pct = 60;
        endcase
      end
      target = items_sent + PhaseItems;
      while (items_sent < target) begin
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
          idle_gap();
          send_item(OpEncode, rand_value(), 8'($urandom));
        end else if (sel < 95) begin
          // well-formed byte sequence, or one that runs to the byte limit
          maxb = model_long ? LongMaxBytes : IntMaxBytes;
          n    = (sel < 85) ? $urandom_range(1, maxb) : maxb;
          for (int i = 0; i < n; i++) begin
            cont = (sel >= 85) || (i != n - 1);
            idle_gap();
            send_item(OpDecode, {$urandom, $urandom}, {cont, 7'($urandom)});
          end
        end else begin
          idle_gap();
          send_item(OpDecode, {$urandom, $urandom}, 8'($urandom));
        end
      end
    end

    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
